// ===== hw/rtl/afpd_pkg.sv =====
package afpd_pkg;

  // Sweep capacity and derived widths
  localparam int unsigned MAX_POSITIONS = 1024;
  localparam int unsigned POS_W = $clog2(MAX_POSITIONS + 1);
  localparam int unsigned IDX_W = $clog2(MAX_POSITIONS);

  // Field widths
  localparam int unsigned SAMPLE_W    = 32;
  localparam int unsigned RUN_W       = 4;
  localparam int unsigned MAX_INDEX_W = 10;
  localparam int unsigned OUT_DATA_W  = 16;

  localparam logic [RUN_W-1:0] RUN_LENGTH_RESET = RUN_W'(3);
  localparam logic [RUN_W-1:0] COUNT_MAX        = {RUN_W{1'b1}};

  // One input word as held in the input stage
  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                last;
  } sample_t;

  // Sweep result handed from the tracker to the output stage
  typedef struct packed {
    logic                   ovf;
    logic                   confirmed;
    logic [MAX_INDEX_W-1:0] max_index;
  } result_t;

endpackage

// ===== hw/rtl/afpd_track.sv =====
module afpd_track import afpd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  sample_t          word_i,
  input  logic [RUN_W-1:0] run_length_i,
  output result_t          result_o
);

  logic [SAMPLE_W-1:0] prev_q, prev_d;
  logic [POS_W-1:0]    pos_q, pos_d;
  logic [RUN_W-1:0]    rise_cnt_q, rise_cnt_d;
  logic [RUN_W-1:0]    fall_cnt_q, fall_cnt_d;
  logic [IDX_W-1:0]    rise_end_q, rise_end_d;
  logic                rise_vld_q, rise_vld_d;
  logic [IDX_W-1:0]    fall_start_q, fall_start_d;
  logic                fall_vld_q, fall_vld_d;
  logic [SAMPLE_W-1:0] best_q, best_d;
  logic [IDX_W-1:0]    best_pos_q, best_pos_d;
  logic                conf_q, conf_d;
  logic                ovf_q, ovf_d;

  logic [RUN_W-1:0]    need;
  logic [IDX_W-1:0]    pos_idx;
  logic                in_range;
  logic                first;
  logic [SAMPLE_W-1:0] s;

  assign s        = word_i.sample;
  assign need     = (run_length_i == '0) ? RUN_W'(1) : run_length_i;
  assign in_range = pos_q < POS_W'(MAX_POSITIONS);
  assign pos_idx  = pos_q[IDX_W-1:0];
  assign first    = pos_q == '0;

  // Update the sweep state for one sample
  always_comb begin
    prev_d       = prev_q;
    pos_d        = pos_q;
    rise_cnt_d   = rise_cnt_q;
    fall_cnt_d   = fall_cnt_q;
    rise_end_d   = rise_end_q;
    rise_vld_d   = rise_vld_q;
    fall_start_d = fall_start_q;
    fall_vld_d   = fall_vld_q;
    best_d       = best_q;
    best_pos_d   = best_pos_q;
    conf_d       = conf_q;
    ovf_d        = ovf_q;

    if (in_range) begin
      // Track the first greatest sample
      if (first || s > best_q) begin
        best_d     = s;
        best_pos_d = pos_idx;
        conf_d     = 1'b0;
      end

      // Count rises and falls, skip equal neighbors
      if (!first && s != prev_q) begin
        if (s > prev_q) begin
          if (rise_cnt_q < COUNT_MAX) rise_cnt_d = rise_cnt_q + RUN_W'(1);
          fall_cnt_d = '0;
          if (rise_cnt_d >= need) begin
            rise_end_d = pos_idx;
            rise_vld_d = 1'b1;
          end
        end else begin
          if (fall_cnt_q == '0) begin
            fall_start_d = pos_idx - IDX_W'(1);
            fall_vld_d   = 1'b0;
          end
          if (fall_cnt_q < COUNT_MAX) fall_cnt_d = fall_cnt_q + RUN_W'(1);
          rise_cnt_d = '0;
          if (fall_cnt_d >= need) fall_vld_d = 1'b1;
        end
        if (rise_vld_d && fall_vld_d && rise_end_d == best_pos_d &&
            fall_start_d == best_pos_d) begin
          conf_d = 1'b1;
        end
      end

      prev_d = s;
      pos_d  = pos_q + POS_W'(1);
    end else begin
      ovf_d = 1'b1;
    end
  end

  // Result of the sweep as it stands after this sample
  assign result_o.max_index = MAX_INDEX_W'(best_pos_d);
  assign result_o.confirmed = conf_d;
  assign result_o.ovf       = ovf_d;

  // Hold state; clear it after the last word of a sweep
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q       <= '0;
      pos_q        <= '0;
      rise_cnt_q   <= '0;
      fall_cnt_q   <= '0;
      rise_end_q   <= '0;
      rise_vld_q   <= 1'b0;
      fall_start_q <= '0;
      fall_vld_q   <= 1'b0;
      best_q       <= '0;
      best_pos_q   <= '0;
      conf_q       <= 1'b0;
      ovf_q        <= 1'b0;
    end else if (step_i) begin
      if (word_i.last) begin
        prev_q       <= '0;
        pos_q        <= '0;
        rise_cnt_q   <= '0;
        fall_cnt_q   <= '0;
        rise_end_q   <= '0;
        rise_vld_q   <= 1'b0;
        fall_start_q <= '0;
        fall_vld_q   <= 1'b0;
        best_q       <= '0;
        best_pos_q   <= '0;
        conf_q       <= 1'b0;
        ovf_q        <= 1'b0;
      end else begin
        prev_q       <= prev_d;
        pos_q        <= pos_d;
        rise_cnt_q   <= rise_cnt_d;
        fall_cnt_q   <= fall_cnt_d;
        rise_end_q   <= rise_end_d;
        rise_vld_q   <= rise_vld_d;
        fall_start_q <= fall_start_d;
        fall_vld_q   <= fall_vld_d;
        best_q       <= best_d;
        best_pos_q   <= best_pos_d;
        conf_q       <= conf_d;
        ovf_q        <= ovf_d;
      end
    end
  end

endmodule

// ===== hw/rtl/autofocus_peak_detector.sv =====
// Contrast autofocus peak search.
// Slave stream: one contrast sample per focus position in s_axis_tdata, with
// s_axis_tlast on the last sample of a sweep. Master stream: one word per
// sweep in m_axis_tdata carrying the position of the first greatest sample,
// the peak confirmation flag and the overflow flag. cfg_we_i/cfg_wdata_i
// write run_length (reset 3); write it only between sweeps with no word in
// flight.
// Throughput: one sample per cycle while s_axis_tready is high. Each sample
// is registered, then the tracker updates its state from that register.
// A sweep result reaches m_axis through the input register, then the result
// register. Reset clears the sweep state and the valid bits of both
// registers; state also clears after each last sample. When the receiver
// stalls, the result waits in the result register while samples keep
// flowing; only a second last sample finding the result register still
// occupied holds s_axis_tready low. Samples beyond 1024 in a sweep are
// dropped and set the overflow flag.
module autofocus_peak_detector import afpd_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // [31:0] contrast_sample
  input  logic [SAMPLE_W-1:0]   s_axis_tdata,
  input  logic                  s_axis_tlast,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // [9:0] max_index, [10] peak_confirmed, [11] sweep_overflow, [15:12] zero
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  input  logic                  cfg_we_i,
  input  logic [RUN_W-1:0]      cfg_wdata_i
);

  logic [RUN_W-1:0] run_length_q;
  sample_t          in_word_q;
  logic             in_vld_q;
  result_t          res_q;
  logic             out_vld_q;
  result_t          track_res;
  logic             advance;
  logic             out_free;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_length_q <= RUN_LENGTH_RESET;
    end else if (cfg_we_i) begin
      run_length_q <= cfg_wdata_i;
    end
  end

  // Advance the input word unless it ends a sweep and the result is blocked
  assign out_free      = !out_vld_q || m_axis_tready;
  assign advance       = in_vld_q && (!in_word_q.last || out_free);
  assign s_axis_tready = !in_vld_q || advance;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_word_q.sample <= s_axis_tdata;
      in_word_q.last   <= s_axis_tlast;
    end
  end

  afpd_track u_track (
    .clk_i,
    .rst_ni,
    .step_i       (advance),
    .word_i       (in_word_q),
    .run_length_i (run_length_q),
    .result_o     (track_res)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance && in_word_q.last) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_word_q.last) begin
      res_q <= track_res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = OUT_DATA_W'({res_q.ovf, res_q.confirmed, res_q.max_index});

endmodule

// ===== hw/rtl/afpd_checker.sv =====
module afpd_checker import afpd_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic                  s_axis_tlast,
  input logic [OUT_DATA_W-1:0] m_axis_tdata,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready
);

  // Hold a stalled result word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result word changed");

  // Keep padding bits of the result word at zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[OUT_DATA_W-1:MAX_INDEX_W+2] == '0)
    else $error("result padding bits not zero");

  // A fresh result follows an accepted last word of a sweep
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready && s_axis_tlast, 2))
    else $error("result without a preceding sweep end");

  // Stall input only behind a result that the receiver holds off
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled with no blocked result");

endmodule

bind autofocus_peak_detector afpd_checker u_afpd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready)
);

// ===== tb/tb_autofocus_peak_detector.sv =====
`timescale 1ns / 100ps

module tb_autofocus_peak_detector;
  import afpd_pkg::*;

  localparam int unsigned QUIET_LIMIT = 3000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned TAIL_CYCLES = 4;
  localparam int unsigned ITEM_GOAL   = 600;
  localparam int unsigned PHASES      = 8;

  // Running state of one sweep as the tracker sees it
  typedef struct packed {
    logic [SAMPLE_W-1:0] prev;
    logic [POS_W-1:0]    pos;
    logic [RUN_W-1:0]    rises;
    logic [RUN_W-1:0]    falls;
    logic [IDX_W-1:0]    rise_end_pos;
    logic                rise_end_ok;
    logic [IDX_W-1:0]    fall_start_pos;
    logic                fall_start_ok;
    logic [SAMPLE_W-1:0] best;
    logic [IDX_W-1:0]    best_pos;
    logic                confirmed;
    logic                overflow;
  } sweep_state_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic [SAMPLE_W-1:0]   s_axis_tdata = '0;
  logic                  s_axis_tlast = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [RUN_W-1:0]      cfg_wdata_i = '0;

  sample_t      sample_q[$];
  result_t      sweep_results_q[$];
  sweep_state_t sweep_st = '0;
  logic [RUN_W-1:0] peak_run_len = RUN_LENGTH_RESET;

  int unsigned err_count = 0;
  int unsigned items_queued = 0;
  int unsigned samples_taken = 0;
  int unsigned sweeps_checked = 0;
  int unsigned peaks_seen = 0;
  int unsigned quiet_cycles = 0;

  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  int unsigned rx_tick = 0;
  int unsigned rx_hold_left = 0;
  logic [31:0] rx_mask = '1;
  bit          rx_hold_req = 1'b0;
  bit          rx_hold_done = 1'b0;

  sample_t drv_item;
  result_t exp_res;
  result_t got_res;

  autofocus_peak_detector i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Hold reset low, then release it
  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Advance the peak search by one sample; return 1 when the sweep closes
  function automatic bit focus_step(input logic [SAMPLE_W-1:0] s, input logic last,
                                    output result_t res);
    logic [RUN_W-1:0] need;
    logic [IDX_W-1:0] p;
    need = (peak_run_len == '0) ? RUN_W'(1) : peak_run_len;
    res = '0;
    if (sweep_st.pos < POS_W'(MAX_POSITIONS)) begin
      p = sweep_st.pos[IDX_W-1:0];
      // first greatest sample wins
      if (sweep_st.pos == '0 || s > sweep_st.best) begin
        sweep_st.best = s;
        sweep_st.best_pos = p;
        sweep_st.confirmed = 1'b0;
      end
      // equal neighbors neither count nor break a run
      if (sweep_st.pos != '0 && s != sweep_st.prev) begin
        if (s > sweep_st.prev) begin
          if (sweep_st.rises != COUNT_MAX) sweep_st.rises++;
          sweep_st.falls = '0;
          if (sweep_st.rises >= need) begin
            sweep_st.rise_end_pos = p;
            sweep_st.rise_end_ok = 1'b1;
          end
        end else begin
          if (sweep_st.falls == '0) begin
            sweep_st.fall_start_pos = p - IDX_W'(1);
            sweep_st.fall_start_ok = 1'b0;
          end
          if (sweep_st.falls != COUNT_MAX) sweep_st.falls++;
          sweep_st.rises = '0;
          if (sweep_st.falls >= need) sweep_st.fall_start_ok = 1'b1;
        end
        if (sweep_st.rise_end_ok && sweep_st.fall_start_ok &&
            sweep_st.rise_end_pos == sweep_st.best_pos &&
            sweep_st.fall_start_pos == sweep_st.best_pos) begin
          sweep_st.confirmed = 1'b1;
        end
      end
      sweep_st.prev = s;
      sweep_st.pos++;
    end else begin
      // past capacity: drop the sample, remember it
      sweep_st.overflow = 1'b1;
    end
    if (!last) return 1'b0;
    res.max_index = sweep_st.best_pos;
    res.confirmed = sweep_st.confirmed;
    res.ovf = sweep_st.overflow;
    sweep_st = '0;
    return 1'b1;
  endfunction

  task automatic flag_error(input string what, input logic [31:0] got,
                            input logic [31:0] want);
    $display("ERROR %0t: %s: got 0x%0h, want 0x%0h", $time, what, got, want);
    err_count++;
  endtask

  // Queue one sweep, last flag on its final sample, and predict its result
  task automatic emit_sweep(input logic [SAMPLE_W-1:0] vals[$]);
    sample_t it;
    result_t r;
    foreach (vals[i]) begin
      it.sample = vals[i];
      it.last = (i == vals.size() - 1);
      sample_q.push_back(it);
      items_queued++;
      if (focus_step(it.sample, it.last, r)) sweep_results_q.push_back(r);
    end
  endtask

  function automatic logic [SAMPLE_W-1:0] rand_step();
    if ($urandom_range(0, 4) == 0) return '0;
    return SAMPLE_W'(1 + ($urandom >> $urandom_range(4, 31)));
  endfunction

  // Rise to a peak and fall away, with equal neighbors and ties mixed in
  task automatic add_peak_sweep();
    logic [SAMPLE_W-1:0] vals[$];
    logic [SAMPLE_W-1:0] down[$];
    logic [SAMPLE_W-1:0] top;
    logic [SAMPLE_W-1:0] v;
    logic [SAMPLE_W-1:0] st;
    int unsigned want;
    int unsigned rise_n;
    int unsigned fall_n;
    want = (peak_run_len == '0) ? 1 : int'(peak_run_len);
    top = ($urandom_range(0, 7) == 0) ? '1 : $urandom;
    rise_n = $urandom_range(0, want + 2);
    fall_n = $urandom_range(0, want + 2);
    repeat ($urandom_range(0, 2)) vals.push_back($urandom & top);
    // walk down from the top, building the rise in ascending order
    v = top;
    repeat (rise_n) begin
      st = rand_step();
      v = (v > st) ? v - st : '0;
      down.push_front(v);
    end
    foreach (down[i]) vals.push_back(down[i]);
    vals.push_back(top);
    v = top;
    repeat (fall_n) begin
      st = rand_step();
      v = (v > st) ? v - st : '0;
      vals.push_back(v);
    end
    if ($urandom_range(0, 5) == 0) vals.push_back(top);
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 3)) vals.push_back($urandom & top);
    end
    emit_sweep(vals);
  endtask

  // Short sweep of random values, often from a narrow range to force ties
  task automatic add_noise_sweep();
    logic [SAMPLE_W-1:0] vals[$];
    int unsigned span;
    span = ($urandom_range(0, 1) == 0) ? 3 : 1000;
    repeat ($urandom_range(1, 14)) vals.push_back(SAMPLE_W'($urandom_range(0, span)));
    emit_sweep(vals);
  endtask

  // Sweep of one repeated value, or a single sample
  task automatic add_flat_sweep(input int unsigned n);
    logic [SAMPLE_W-1:0] vals[$];
    logic [SAMPLE_W-1:0] v;
    v = $urandom;
    repeat (n) vals.push_back(v);
    emit_sweep(vals);
  endtask

  // Long monotonic runs that push both counters into saturation
  task automatic add_long_sweep(input int unsigned rise_n, input int unsigned fall_n);
    logic [SAMPLE_W-1:0] vals[$];
    for (int unsigned i = 0; i <= rise_n; i++) vals.push_back(SAMPLE_W'(100 + 7 * i));
    for (int unsigned i = 1; i <= fall_n; i++) begin
      vals.push_back(SAMPLE_W'(100 + 7 * rise_n - 5 * i));
    end
    emit_sweep(vals);
  endtask

  task automatic wait_idle();
    while (sample_q.size() != 0 || sweep_results_q.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic [RUN_W-1:0] v);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    peak_run_len = v;
  endtask

  // Drive input words in bursts with random gaps
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (gap_left > 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (sample_q.size() > 0) begin
        drv_item = sample_q.pop_front();
        s_axis_tdata  <= drv_item.sample;
        s_axis_tlast  <= drv_item.last;
        s_axis_tvalid <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 40);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Stall the receiver on its own pattern, with one long hold on request
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (rx_hold_left > 0) begin
      rx_hold_left--;
      if (rx_hold_left == 0) rx_hold_done = 1'b1;
      m_axis_tready <= 1'b0;
    end else if (rx_hold_req && !rx_hold_done) begin
      rx_hold_left = HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else begin
      rx_tick++;
      if (rx_tick % 64 == 0) rx_mask = $urandom;
      m_axis_tready <= rx_mask[rx_tick % 32] | ($urandom_range(0, 3) == 0);
    end
  end

  // Check each result word against the prediction
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) samples_taken++;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (sweep_results_q.size() == 0) begin
        flag_error("unexpected result word", 32'(m_axis_tdata), '0);
      end else begin
        exp_res = sweep_results_q.pop_front();
        got_res = result_t'(m_axis_tdata[MAX_INDEX_W+1:0]);
        if (got_res !== exp_res) flag_error("sweep result", 32'(got_res), 32'(exp_res));
        if (m_axis_tdata[OUT_DATA_W-1:MAX_INDEX_W+2] !== '0) begin
          flag_error("result padding", 32'(m_axis_tdata), 32'(exp_res));
        end
        sweeps_checked++;
        if (exp_res.confirmed) peaks_seen++;
      end
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("ERROR %0t: no word moved for %0d cycles", $time, QUIET_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Stimulus: phases of sweeps, each under its own run length
  initial begin
    int unsigned plan [PHASES];
    int unsigned kind;
    plan = '{3, 1, 0, 15, 5, 2, 4, 3};
    @(posedge rst_ni);
    repeat (2) @(posedge clk_i);
    for (int unsigned ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      write_cfg(RUN_W'(plan[ph]));
      if (ph == 1) rx_hold_req = 1'b1;
      if (plan[ph] == 15) begin
        add_long_sweep(19, 20);
        add_long_sweep(14, 20);
        add_long_sweep(20, 14);
      end
      if (ph == 2) begin
        add_flat_sweep(1);
        add_flat_sweep(6);
      end
      while (items_queued < (ph + 1) * ITEM_GOAL / PHASES) begin
        kind = $urandom_range(0, 9);
        if (kind < 6) add_peak_sweep();
        else if (kind < 8) add_noise_sweep();
        else if (kind == 8) add_flat_sweep($urandom_range(2, 5));
        else add_flat_sweep(1);
      end
    end
    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (samples_taken != items_queued) flag_error("samples accepted", samples_taken, items_queued);
    $display("Ran %0d samples in %0d sweeps over run lengths 0 to 15, %0d peaks confirmed,",
             samples_taken, sweeps_checked, peaks_seen);
    $display("with ties, flat and single-sample sweeps, saturated runs and a long receiver hold.");
    if (err_count == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
